// ===== design/bbc_pkg.sv =====
// package for the bitplane blitter copy engine: codes, widths, minterm function
package bbc_pkg;
  localparam int unsigned ChipBytesDefault = 524288;
  localparam int unsigned PtrW = 21;
  localparam logic [PtrW-1:0] PtrMask = 21'h1ffffe;

  typedef enum logic [1:0] {
    CmdWrite = 2'd0,
    CmdRead  = 2'd1,
    CmdPtr   = 2'd2,
    CmdBlit  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    RegCon0  = 3'd0,
    RegCon1  = 3'd1,
    RegFwm   = 3'd2,
    RegLwm   = 3'd3,
    RegMod   = 3'd4,
    RegFixed = 3'd5
  } reg_e;

  function automatic logic [15:0] minterm(logic [7:0] fn, logic [15:0] a,
                                          logic [15:0] b, logic [15:0] c);
    logic [15:0] d;
    d = '0;
    for (int i = 0; i < 8; i++) begin
      if (fn[i]) begin
        d = d | ((i[2] ? a : ~a) & (i[1] ? b : ~b) & (i[0] ? c : ~c));
      end
    end
    return d;
  endfunction
endpackage

// ===== design/bitplane_blitter_copy.sv =====
// top level of the bitplane blitter copy engine: command sequencer and blit datapath
// Usage: raise start with command_i and its operand ports while busy is low.
// Each command gives exactly one result word: done_o is high for one cycle with
// read_word_o (read data for a read command, zero otherwise), all_zero_o and
// blits_done_o. The receiver cannot stall; results are never held.
// done_o is registered: for write and pointer commands it rises in the cycle after
// acceptance, and a read first passes through StRdDone.
// A blit of h rows of w words runs per word through StFetch and StFetchWait for each
// enabled channel A, B, C and through StFetch alone for each disabled one, then a
// dispatch StFetch and StCalc, which writes D when it is enabled; per row StRowEnd
// adds the modulo, and StFin ends the blit. All of it shares the single memory port.
// A size field of zero stands for 1024 rows or 64 words.
// Commands are taken one at a time; busy is low again in the cycle of done_o.
// Configuration writes go through cfg_we_i, cfg_index_i and cfg_data_i; the user must make
// them only while idle, as the block does not enforce it. Unknown indexes are ignored.
// Reset clears the registers (the word masks go to all ones), pointers, the zero flag and
// the blit counter; the memory is not cleared and must be written before it is read.
module bitplane_blitter_copy import bbc_pkg::*; #(
  parameter int unsigned ChipBytes = ChipBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [20:0] byte_address_i,
  input  logic [1:0]  channel_i,
  input  logic [15:0] write_word_i,
  input  logic [15:0] blit_size_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        done_o,
  output logic [15:0] read_word_o,
  output logic        all_zero_o,
  output logic [15:0] blits_done_o
);
  localparam int unsigned AW = $clog2(ChipBytes / 2);

  typedef enum logic [3:0] {
    StIdle, StRdDone, StFetch, StFetchWait, StCalc, StRowEnd, StFin
  } state_e;

  state_e      state_q;
  logic [15:0] con0_q, con1_q, fwm_q, lwm_q;
  logic [63:0] mod_q;
  logic [47:0] fixed_q;
  logic [PtrW-1:0] ptr_q [4];
  logic        zero_q;
  logic [15:0] cnt_q;
  logic [9:0]  hcnt_q;
  logic [5:0]  wcnt_q, width_q;
  logic [1:0]  ch_q;
  logic        first_q;
  logic [15:0] araw_q, braw_q, craw_q, aprev_q, bprev_q;
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0] mem_wdata, mem_rdata;

  logic [15:0] am, a_sh, b_sh, d_val;
  logic [3:0]  ash, bsh;
  logic        desc;
  logic [3:0]  use_ch;
  logic        last_w;
  logic [PtrW-1:0] step;

  assign ash = con0_q[15:12];
  assign bsh = con1_q[15:12];
  assign desc = con1_q[1];
  assign use_ch = {con0_q[8], con0_q[9], con0_q[10], con0_q[11]};
  assign step = desc ? {{(PtrW-2){1'b1}}, 2'b10} : PtrW'(2);
  assign last_w = (wcnt_q == width_q);

  function automatic logic [15:0] shw(logic [15:0] raw, logic [15:0] prev,
                                     logic [3:0] sh, logic dn);
    logic [31:0] t;
    t = '0;
    if (!dn) begin
      t = {prev, raw} >> sh;
    end else if (sh == 4'd0) begin
      t = {16'd0, raw};
    end else begin
      t = {raw, prev} >> (5'd16 - {1'b0, sh});
    end
    return t[15:0];
  endfunction

  always_comb begin
    am = araw_q;
    if (first_q) am = am & fwm_q;
    if (last_w) am = am & lwm_q;
    a_sh = shw(am, aprev_q, ash, desc);
    b_sh = shw(braw_q, bprev_q, bsh, desc);
    d_val = minterm(con0_q[7:0], a_sh, b_sh, craw_q);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wdata = write_word_i;
    mem_addr = byte_address_i[AW:1];
    if (state_q == StIdle) begin
      mem_we = start && (command_i == CmdWrite);
    end else if (state_q == StCalc) begin
      mem_we = use_ch[3];
      mem_wdata = d_val;
      mem_addr = ptr_q[3][AW:1];
    end else begin
      mem_addr = ptr_q[ch_q][AW:1];
    end
  end

  bbc_mem #(.ChipBytes(ChipBytes)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign busy = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      con0_q <= '0;
      con1_q <= '0;
      fwm_q <= 16'hffff;
      lwm_q <= 16'hffff;
      mod_q <= '0;
      fixed_q <= '0;
      for (int i = 0; i < 4; i++) ptr_q[i] <= '0;
      zero_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
      read_word_o <= '0;
      hcnt_q <= '0;
      wcnt_q <= '0;
      width_q <= '0;
      ch_q <= '0;
      first_q <= 1'b0;
      araw_q <= '0;
      braw_q <= '0;
      craw_q <= '0;
      aprev_q <= '0;
      bprev_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegCon0:  con0_q <= cfg_data_i[15:0];
          RegCon1:  con1_q <= cfg_data_i[15:0];
          RegFwm:   fwm_q <= cfg_data_i[15:0];
          RegLwm:   lwm_q <= cfg_data_i[15:0];
          RegMod:   mod_q <= cfg_data_i;
          RegFixed: fixed_q <= cfg_data_i[47:0];
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (start) begin
            read_word_o <= '0;
            unique case (cmd_e'(command_i))
              CmdWrite: begin
                done_o <= 1'b1;
              end
              CmdRead: state_q <= StRdDone;
              CmdPtr: begin
                ptr_q[channel_i] <= byte_address_i & PtrMask;
                done_o <= 1'b1;
              end
              CmdBlit: begin
                hcnt_q <= blit_size_i[15:6] - 10'd1;
                width_q <= blit_size_i[5:0] - 6'd1;
                wcnt_q <= '0;
                first_q <= 1'b1;
                zero_q <= 1'b1;
                aprev_q <= '0;
                bprev_q <= '0;
                ch_q <= 2'd0;
                state_q <= StFetch;
              end
              default: ;
            endcase
          end
        end
        StRdDone: begin
          read_word_o <= mem_rdata;
          done_o <= 1'b1;
          state_q <= StIdle;
        end
        StFetch: begin
          if (ch_q == 2'd3) begin
            state_q <= StCalc;
          end else if (use_ch[ch_q]) begin
            state_q <= StFetchWait;
          end else begin
            case (ch_q)
              2'd0: araw_q <= fixed_q[15:0];
              2'd1: braw_q <= fixed_q[31:16];
              default: craw_q <= fixed_q[47:32];
            endcase
            ch_q <= ch_q + 2'd1;
          end
        end
        StFetchWait: begin
          case (ch_q)
            2'd0: araw_q <= mem_rdata;
            2'd1: braw_q <= mem_rdata;
            default: craw_q <= mem_rdata;
          endcase
          ch_q <= ch_q + 2'd1;
          state_q <= StFetch;
        end
        StCalc: begin
          if (d_val != 16'd0) zero_q <= 1'b0;
          aprev_q <= am;
          bprev_q <= braw_q;
          for (int i = 0; i < 4; i++) begin
            if (use_ch[i]) ptr_q[i] <= (ptr_q[i] + step) & PtrMask;
          end
          first_q <= 1'b0;
          ch_q <= 2'd0;
          wcnt_q <= wcnt_q + 6'd1;
          state_q <= last_w ? StRowEnd : StFetch;
        end
        StRowEnd: begin
          for (int i = 0; i < 4; i++) begin
            if (use_ch[i]) begin
              if (desc) begin
                ptr_q[i] <= (ptr_q[i] - PtrW'({{5{mod_q[16*i+15]}},
                            mod_q[16*i+1 +: 15], 1'b0})) & PtrMask;
              end else begin
                ptr_q[i] <= (ptr_q[i] + PtrW'({{5{mod_q[16*i+15]}},
                            mod_q[16*i+1 +: 15], 1'b0})) & PtrMask;
              end
            end
          end
          wcnt_q <= '0;
          first_q <= 1'b1;
          aprev_q <= '0;
          bprev_q <= '0;
          hcnt_q <= hcnt_q - 10'd1;
          state_q <= (hcnt_q == 10'd0) ? StFin : StFetch;
        end
        StFin: begin
          cnt_q <= cnt_q + 16'd1;
          done_o <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign all_zero_o = zero_q;
  assign blits_done_o = cnt_q;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o)) else $error("command lost");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> done_o) else $error("counter moved silently");
  a_ptr_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ptr_q[3][0]) else $error("odd pointer");
`endif
endmodule

// ===== design/bbc_mem.sv =====
// chip memory: single port synchronous ram with registered read data
module bbc_mem import bbc_pkg::*; #(
  parameter int unsigned ChipBytes = ChipBytesDefault
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(ChipBytes/2)-1:0] addr_i,
  input  logic [15:0]                    wdata_i,
  output logic [15:0]                    rdata_o
);
  localparam int unsigned Words = ChipBytes / 2;
  logic [15:0] mem_q [Words];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== bench/bbc_checker.sv =====
// checker for the blitter copy engine: watches commands and config writes, predicts and compares results
module bbc_checker import bbc_pkg::*; #(
  parameter int unsigned ChipBytes = ChipBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  command_i,
  input  logic [20:0] byte_address_i,
  input  logic [1:0]  channel_i,
  input  logic [15:0] write_word_i,
  input  logic [15:0] blit_size_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        done_i,
  input  logic [15:0] read_word_i,
  input  logic        all_zero_i,
  input  logic [15:0] blits_done_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] rd;
    logic        zero;
    logic [15:0] count;
  } status_t;

  logic [15:0] con0, con1, fwm, lwm;
  logic [63:0] mods;
  logic [47:0] fixed_words;
  logic [15:0] chip_words [int unsigned];
  logic [20:0] ptrs [4];
  logic        zflag;
  logic [15:0] nblits;
  status_t     status_q [$];
  int          fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = status_q.size();

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  function automatic int unsigned idx_of(logic [20:0] a);
    return (32'(a) & (ChipBytes - 1)) >> 1;
  endfunction

  function automatic logic [15:0] mem_rd(logic [20:0] a);
    return chip_words.exists(idx_of(a)) ? chip_words[idx_of(a)] : 16'h0;
  endfunction

  function automatic logic [15:0] mix(logic [7:0] fn, logic [15:0] a, logic [15:0] b,
                                      logic [15:0] c);
    logic [15:0] d;
    for (int i = 0; i < 16; i++) d[i] = fn[{a[i], b[i], c[i]}];
    return d;
  endfunction

  function automatic logic [15:0] shifted(logic [15:0] raw, logic [15:0] prev,
                                          logic [3:0] sh, logic desc);
    logic [31:0] w;
    if (!desc) begin
      w = {prev, raw} >> sh;
    end else if (sh == 4'd0) begin
      w = {16'h0, raw};
    end else begin
      w = {raw, prev} >> (16 - sh);
    end
    return w[15:0];
  endfunction

  function automatic void run_blit(logic [15:0] size);
    int unsigned rows, cols;
    logic [3:0]  use_ch;
    logic        desc;
    logic [20:0] step, m;
    logic [15:0] araw, braw, cw, a, b, d, aprev, bprev;
    rows   = (size[15:6] == 0) ? 1024 : size[15:6];
    cols   = (size[5:0] == 0) ? 64 : size[5:0];
    use_ch = {con0[8], con0[9], con0[10], con0[11]};
    desc   = con1[1];
    step   = desc ? 21'h1ffffe : 21'd2;
    zflag  = 1'b1;
    for (int unsigned y = 0; y < rows; y++) begin
      aprev = '0;
      bprev = '0;
      for (int unsigned x = 0; x < cols; x++) begin
        araw = use_ch[0] ? mem_rd(ptrs[0]) : fixed_words[15:0];
        braw = use_ch[1] ? mem_rd(ptrs[1]) : fixed_words[31:16];
        cw   = use_ch[2] ? mem_rd(ptrs[2]) : fixed_words[47:32];
        if (x == 0) araw &= fwm;
        if (x == cols - 1) araw &= lwm;
        a = shifted(araw, aprev, con0[15:12], desc);
        b = shifted(braw, bprev, con1[15:12], desc);
        aprev = araw;
        bprev = braw;
        d = mix(con0[7:0], a, b, cw);
        if (d != 16'h0) zflag = 1'b0;
        for (int ch = 0; ch < 3; ch++) begin
          if (use_ch[ch]) ptrs[ch] = (ptrs[ch] + step) & PtrMask;
        end
        if (use_ch[3]) begin
          chip_words[idx_of(ptrs[3])] = d;
          ptrs[3] = (ptrs[3] + step) & PtrMask;
        end
      end
      for (int ch = 0; ch < 4; ch++) begin
        if (use_ch[ch]) begin
          m = 21'(signed'(mods[16*ch +: 16] & 16'hfffe));
          ptrs[ch] = (desc ? ptrs[ch] - m : ptrs[ch] + m) & PtrMask;
        end
      end
    end
    nblits++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    status_t     want;
    logic [15:0] rdv;
    if (!rst_ni) begin
      con0        = '0;
      con1        = '0;
      fwm         = 16'hffff;
      lwm         = 16'hffff;
      mods        = '0;
      fixed_words = '0;
      for (int ch = 0; ch < 4; ch++) ptrs[ch] = '0;
      zflag       = 1'b0;
      nblits      = '0;
      status_q.delete();
    end else begin
      if (done_i) begin
        if (status_q.size() == 0) begin
          report_mismatch("result word with none expected", read_word_i, 16'h0);
        end else begin
          want = status_q.pop_front();
          if (read_word_i !== want.rd) report_mismatch("read_word", read_word_i, want.rd);
          if (all_zero_i !== want.zero) begin
            report_mismatch("all_zero", 16'(all_zero_i), 16'(want.zero));
          end
          if (blits_done_i !== want.count) begin
            report_mismatch("blits_done", blits_done_i, want.count);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegCon0:  con0 = cfg_data_i[15:0];
          RegCon1:  con1 = cfg_data_i[15:0];
          RegFwm:   fwm = cfg_data_i[15:0];
          RegLwm:   lwm = cfg_data_i[15:0];
          RegMod:   mods = cfg_data_i;
          RegFixed: fixed_words = cfg_data_i[47:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        rdv = '0;
        case (command_i)
          CmdWrite: chip_words[idx_of(byte_address_i)] = write_word_i;
          CmdRead:  rdv = mem_rd(byte_address_i);
          CmdPtr:   ptrs[channel_i] = byte_address_i & PtrMask;
          default:  run_blit(blit_size_i);
        endcase
        status_q.push_back('{rd: rdv, zero: zflag, count: nblits});
      end
    end
  end
endmodule

// ===== bench/tb_bitplane_blitter_copy.sv =====
// testbench top for the blitter copy engine: reset, clock, command and config stimulus, verdict
module tb_bitplane_blitter_copy;
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = '0;
  logic [20:0] byte_address = '0;
  logic [1:0]  channel = '0;
  logic [15:0] write_word = '0;
  logic [15:0] blit_size = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        done;
  logic [15:0] read_word;
  logic        all_zero;
  logic [15:0] blits_done;
  int          fails;
  int          pending;
  bit          quiet = 1'b0;

  bitplane_blitter_copy DUT (
    .clk_i, .rst_ni, .start, .busy,
    .command_i(command), .byte_address_i(byte_address), .channel_i(channel),
    .write_word_i(write_word), .blit_size_i(blit_size),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .done_o(done), .read_word_o(read_word), .all_zero_o(all_zero), .blits_done_o(blits_done)
  );

  bbc_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .command_i(command), .byte_address_i(byte_address), .channel_i(channel),
    .write_word_i(write_word), .blit_size_i(blit_size),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .done_i(done), .read_word_i(read_word), .all_zero_i(all_zero), .blits_done_i(blits_done),
    .fail_count_o(fails), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial begin
    #20_000_000;
    $display("tb_bitplane_blitter_copy failed");
    $finish;
  end

  task automatic issue(cmd_e cmd, logic [20:0] addr, logic [1:0] ch, logic [15:0] wd,
                       logic [15:0] size);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    command      <= cmd;
    byte_address <= addr;
    channel      <= ch;
    write_word   <= wd;
    blit_size    <= size;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [63:0] val);
    start <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // source window is bytes 0..63, pointers start near its middle
  function automatic logic [20:0] window_ptr();
    return {2'($urandom), 13'd0, 6'(2 * $urandom_range(14, 18) + $urandom_range(0, 1))};
  endfunction

  task automatic blit_in_window(logic [15:0] size);
    for (int c = 0; c < 4; c++) issue(CmdPtr, window_ptr(), 2'(c), 16'($urandom), 16'($urandom));
    issue(CmdBlit, 21'($urandom), 2'($urandom), 16'($urandom), size);
  endtask

  function automatic logic [15:0] small_mod();
    return 16'($urandom_range(0, 8)) - 16'd4;
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 32; i++) begin
      issue(CmdWrite, 21'(2 * i + $urandom_range(0, 1)), 2'($urandom), 16'($urandom),
            16'($urandom));
    end

    set_reg(RegSpareLo, '1);
    set_reg(RegSpareHi, '1);
    issue(CmdWrite, 21'h1fffff, 2'd3, 16'hffff, 16'hffff);
    issue(CmdRead, 21'h07fffe, 2'd0, 16'h0, 16'h0);
    issue(CmdWrite, 21'h000000, 2'd0, 16'h0000, 16'h0);
    issue(CmdRead, 21'h180001, 2'd1, 16'h0, 16'h0);
    issue(CmdPtr, 21'h1fffff, 2'd3, 16'h0, 16'h0);
    set_reg(RegCon0, 64'h01f0);
    set_reg(RegFixed, 48'hffff_ffff_ffff);
    set_reg(RegMod, 64'h7fff_8001_0001_ffff);
    issue(CmdBlit, 21'h0, 2'd0, 16'h0, 16'h0000);
    set_reg(RegCon0, 64'h0100);
    issue(CmdBlit, 21'h0, 2'd0, 16'h0, {10'd1, 6'd0});
    set_reg(RegCon0, 64'h0000);
    issue(CmdBlit, 21'h0, 2'd0, 16'h0, {10'd0, 6'd1});
    set_reg(RegMod, 64'h0);
    set_reg(RegCon0, 64'hffff);
    set_reg(RegCon1, 64'hffff);
    set_reg(RegFwm, 64'h0000);
    set_reg(RegLwm, 64'hffff);
    blit_in_window({10'd2, 6'd1});
    set_reg(RegCon0, 64'h0fca);
    set_reg(RegCon1, 64'h0002);
    blit_in_window({10'd3, 6'd5});
    set_reg(RegCon0, 64'h5e96);
    set_reg(RegCon1, 64'h7000);
    set_reg(RegFwm, 64'h8001);
    set_reg(RegLwm, 64'h0000);
    set_reg(RegMod, '1);
    blit_in_window({10'd2, 6'd6});
    set_reg(RegFixed, 48'h0);

    for (int it = 0; it < 20; it++) begin
      if (it % 5 == 0) begin
        set_reg(RegCon0, 64'(16'($urandom)));
        set_reg(RegCon1, 64'(16'($urandom)));
        set_reg(RegFwm, 64'(16'($urandom)));
        set_reg(RegLwm, 64'(16'($urandom)));
        set_reg(RegMod, {small_mod(), small_mod(), small_mod(), small_mod()});
        set_reg(RegFixed, {32'($urandom), 32'($urandom)});
        quiet = ($urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2: issue(CmdWrite, 21'($urandom), 2'($urandom), 16'($urandom), 16'($urandom));
        3, 4: issue(CmdRead, {2'($urandom), 13'd0, 6'($urandom)}, 2'($urandom),
                    16'($urandom), 16'($urandom));
        5: issue(CmdPtr, 21'($urandom), 2'($urandom), 16'($urandom), 16'($urandom));
        default: blit_in_window({10'($urandom_range(1, 2)), 6'($urandom_range(1, 3))});
      endcase
    end

    start <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (pending != 0) $display("%0d result words never arrived", pending);
    if (fails == 0 && pending == 0) begin
      $display("tb_bitplane_blitter_copy passed");
    end else begin
      $display("tb_bitplane_blitter_copy failed");
    end
    $finish;
  end
endmodule
